/* rtl/assert_macros.svh */
// Assertion macros shared by the unpacker RTL.
// Included by the top level; needs no package. SYNTH selects empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// The expression must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/tt6u_pkg.sv */
// Types and constants of the six-bit symbol unpacker.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tt6u_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned COUNT_BYTES = (COUNT_BITS + 7) / 8;
  localparam int unsigned CIDX_W      = $clog2(COUNT_BYTES + 1);
  localparam int unsigned QDEPTH      = 2;

  localparam logic [7:0] LEAF_FLAG = 8'h80;
  localparam logic [7:0] SYM_MASK  = 8'h3F;
  localparam logic [7:0] HIGH_MASK = 8'hC0;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       run_last;
    logic       stream_done;
  } out_item_t;

  // Kinds of work handed from the front to the back.
  typedef enum logic [1:0] {
    K_TABLE = 2'd0,
    K_SETUP = 2'd1,
    K_BITS  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e             kind;
    logic [TABLE_AW-1:0]   addr;
    logic [7:0]            data;
    logic [COUNT_BITS-1:0] count;
  } job_t;

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_TABLE = 4'b0010,
    F_COUNT = 4'b0100,
    F_BITS  = 4'b1000
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_WALK  = 4'b0010,
    B_EMIT  = 4'b0100,
    B_FLUSH = 4'b1000
  } back_state_e;

endpackage

/* rtl/tt6u_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tt6u_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tt6u_fifo.sv */
// Short job queue between the front and the back of the unpacker.
// Depends on tt6u_pkg for the job type and depth.
module tt6u_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tt6u_pkg::job_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tt6u_pkg::job_t  item_o
);
  import tt6u_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QDEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    return r;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = CNT_W'(cnt_q + CNT_W'(1));
    end else if (!push_i && pop_i) begin
      cnt_d = CNT_W'(cnt_q - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/tt6u_front.sv */
// Front part: parses the file header and turns bytes into jobs.
// Depends on tt6u_pkg; feeds tt6u_fifo.
module tt6u_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tt6u_pkg::in_item_t data_i,
  input  logic               full_i,
  output logic               push_o,
  output tt6u_pkg::job_t     item_o
);
  import tt6u_pkg::*;

  front_state_e          phase_q, phase_d;
  logic [7:0]            tlen_q, tlen_d;
  logic [TABLE_AW-1:0]   lidx_q, lidx_d;
  logic [CIDX_W-1:0]     cidx_q, cidx_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS+7:0] cnt_shift;
  logic [TABLE_AW-1:0]   lidx_inc;
  logic                  acc;

  assign acc       = valid_i && !full_i;
  assign cnt_shift = {cnt_q, data_i.stream_byte};
  assign lidx_inc  = TABLE_AW'(lidx_q + TABLE_AW'(1));

  always_comb begin
    phase_d = phase_q;
    tlen_d  = tlen_q;
    lidx_d  = lidx_q;
    cidx_d  = cidx_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    item_o  = '{kind: K_BITS, addr: lidx_q, data: data_i.stream_byte, count: cnt_q};
    if (acc) begin
      if (data_i.stream_start) begin
        // A start byte abandons whatever file was in progress.
        tlen_d  = data_i.stream_byte;
        lidx_d  = '0;
        cidx_d  = '0;
        cnt_d   = '0;
        phase_d = (data_i.stream_byte == 8'h00) ? F_COUNT : F_TABLE;
      end else begin
        case (phase_q)
          F_TABLE: begin
            push_o      = 1'b1;
            item_o.kind = K_TABLE;
            lidx_d      = lidx_inc;
            if (8'(lidx_inc) == tlen_q) begin
              phase_d = F_COUNT;
              cidx_d  = '0;
              cnt_d   = '0;
            end
          end
          F_COUNT: begin
            cnt_d = cnt_shift[COUNT_BITS-1:0];
            if (cidx_q == CIDX_W'(COUNT_BYTES - 1)) begin
              push_o       = 1'b1;
              item_o.kind  = K_SETUP;
              item_o.count = cnt_shift[COUNT_BITS-1:0];
              phase_d      = F_BITS;
            end else begin
              cidx_d = CIDX_W'(cidx_q + CIDX_W'(1));
            end
          end
          F_BITS: begin
            push_o = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= F_IDLE;
      tlen_q  <= '0;
      lidx_q  <= '0;
      cidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tlen_q  <= tlen_d;
      lidx_q  <= lidx_d;
      cidx_q  <= cidx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/tt6u_back.sv */
// Back part: loads the code table, walks the tree bit by bit and packs
// groups of four symbols into three bytes. Depends on tt6u_pkg and tt6u_ram.
module tt6u_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  tt6u_pkg::job_t      q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tt6u_pkg::out_item_t out_data_o
);
  import tt6u_pkg::*;

  localparam logic [1:0] EMIT_PREV = 2'd0;
  localparam logic [1:0] EMIT_B0   = 2'd1;
  localparam logic [1:0] EMIT_B1   = 2'd2;

  back_state_e           state_q, state_d;
  logic [COUNT_BITS-1:0] groups_q, groups_d;
  logic                  done_q, done_d;
  logic [7:0]            node_q, node_d;
  logic [1:0]            scnt_q, scnt_d;
  logic [2:0]            bit_q, bit_d;
  logic                  pend_q, pend_d;
  logic                  end_q, end_d;
  logic [1:0]            eidx_q, eidx_d;
  logic                  hold_vld_q, hold_vld_d;
  logic                  hold_done_q, hold_done_d;
  logic [7:0]            hold_q, hold_d;
  logic [7:0]            byte_q, byte_d;
  logic [5:0]            store_q [3];
  logic [5:0]            store_d [3];
  logic [5:0]            grp3_q, grp3_d;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [TABLE_DEPTH-1:0] vld_q;
  logic                   rd_vld_q;
  logic                   ram_we;
  logic [TABLE_AW-1:0]    ram_raddr;
  logic [7:0]             ram_rdata;

  logic [7:0] entry, nxt;
  logic       term;
  logic [5:0] sym;
  logic [2:0] bit_nx;
  logic       out_free, push;
  out_item_t  push_item;
  logic [7:0] gbyte [3];

  tt6u_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_item_i.addr),
    .wdata_i (q_item_i.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries never loaded since reset read as zero.
  assign entry    = rd_vld_q ? ram_rdata : 8'h00;
  assign term     = (entry & LEAF_FLAG) != 8'h00;
  assign sym      = 6'(entry & SYM_MASK);
  assign nxt      = term ? 8'h00 : entry;
  assign bit_nx   = bit_q - 3'd1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gbyte[i] = {2'b00, store_q[i]} | (8'({2'b00, grp3_q} << (2 * i + 2)) & HIGH_MASK);
    end
  end

  always_comb begin
    state_d     = state_q;
    groups_d    = groups_q;
    done_d      = done_q;
    node_d      = node_q;
    scnt_d      = scnt_q;
    bit_d       = bit_q;
    pend_d      = pend_q;
    end_d       = end_q;
    eidx_d      = eidx_q;
    hold_vld_d  = hold_vld_q;
    hold_done_d = hold_done_q;
    hold_d      = hold_q;
    byte_d      = byte_q;
    store_d     = store_q;
    grp3_d      = grp3_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = {node_q[6:0], ~byte_q[bit_q]};
    push        = 1'b0;
    push_item   = '{data_byte: hold_q, run_last: 1'b0, stream_done: hold_done_q};

    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.kind)
            K_TABLE: begin
              ram_we = 1'b1;
            end
            K_SETUP: begin
              groups_d = q_item_i.count;
              done_d   = (q_item_i.count == '0);
              node_d   = '0;
              scnt_d   = '0;
            end
            K_BITS: begin
              if (!done_q) begin
                byte_d  = q_item_i.data;
                bit_d   = 3'd7;
                pend_d  = 1'b0;
                state_d = B_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      B_WALK: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else begin
          node_d = nxt;
          if (term && scnt_q == 2'd3) begin
            grp3_d   = sym;
            scnt_d   = '0;
            groups_d = groups_q - COUNT_BITS'(1);
            end_d    = (bit_q == 3'd0) || (groups_q == COUNT_BITS'(1));
            eidx_d   = EMIT_PREV;
            pend_d   = 1'b0;
            bit_d    = bit_nx;
            state_d  = B_EMIT;
          end else begin
            if (term) begin
              for (int i = 0; i < 3; i++) begin
                if (scnt_q == 2'(i)) begin
                  store_d[i] = sym;
                end
              end
              scnt_d = 2'(scnt_q + 2'd1);
            end
            if (bit_q == 3'd0) begin
              pend_d  = 1'b0;
              state_d = B_FLUSH;
            end else begin
              bit_d     = bit_nx;
              ram_raddr = {nxt[6:0], ~byte_q[bit_nx]};
            end
          end
        end
      end

      B_EMIT: begin
        case (eidx_q)
          EMIT_PREV: begin
            if (!hold_vld_q) begin
              eidx_d = EMIT_B0;
            end else if (out_free) begin
              push       = 1'b1;
              hold_vld_d = 1'b0;
              eidx_d     = EMIT_B0;
            end
          end
          EMIT_B0: begin
            if (out_free) begin
              push      = 1'b1;
              push_item = '{data_byte: gbyte[0], run_last: 1'b0, stream_done: 1'b0};
              eidx_d    = EMIT_B1;
            end
          end
          EMIT_B1: begin
            if (out_free) begin
              push        = 1'b1;
              push_item   = '{data_byte: gbyte[1], run_last: 1'b0, stream_done: 1'b0};
              hold_d      = gbyte[2];
              hold_vld_d  = 1'b1;
              hold_done_d = (groups_q == '0);
              if (groups_q == '0) begin
                done_d = 1'b1;
              end
              state_d = end_q ? B_FLUSH : B_WALK;
            end
          end
          default: begin
            eidx_d = EMIT_PREV;
          end
        endcase
      end

      B_FLUSH: begin
        if (!hold_vld_q) begin
          state_d = B_IDLE;
        end else if (out_free) begin
          push               = 1'b1;
          push_item.run_last = 1'b1;
          hold_vld_d         = 1'b0;
          state_d            = B_IDLE;
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      groups_q    <= '0;
      done_q      <= 1'b0;
      node_q      <= '0;
      scnt_q      <= '0;
      bit_q       <= '0;
      pend_q      <= 1'b0;
      end_q       <= 1'b0;
      eidx_q      <= EMIT_PREV;
      hold_vld_q  <= 1'b0;
      hold_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      groups_q    <= groups_d;
      done_q      <= done_d;
      node_q      <= node_d;
      scnt_q      <= scnt_d;
      bit_q       <= bit_d;
      pend_q      <= pend_d;
      end_q       <= end_d;
      eidx_q      <= eidx_d;
      hold_vld_q  <= hold_vld_d;
      hold_done_q <= hold_done_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[q_item_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    byte_q  <= byte_d;
    store_q <= store_d;
    grp3_q  <= grp3_d;
    if (push) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/table_tree_six_bit_unpacker_unit.sv */
// Top level of the table-driven six-bit symbol unpacker.
// Depends on tt6u_pkg, tt6u_front, tt6u_fifo, tt6u_back and assert_macros.svh.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o   tt6u_pkg::in_item_t
//   output    out        out_valid_o/out_stall_i tt6u_pkg::out_item_t
//
// A table byte or the last count byte becomes one job for the back; a start byte or an
// earlier count byte never reaches the back. A bitstream byte leaves the queue, then
// the back issues the first table read, follows one chained table read per bit (which
// sets the rate) and releases the last result. Each finished group adds its emit steps
// (the held byte of the group before, then its first two bytes), and a restart of the
// read if bits remain. Reset empties the table through one valid flip-flop per entry,
// so there is no clearing pass. Input stalls only while the job queue is full; a stalled
// output holds the back part only when it has a byte to emit, while the front keeps filling the queue.

`include "assert_macros.svh"

module table_tree_six_bit_unpacker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tt6u_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tt6u_pkg::out_item_t out_data_o
);
  import tt6u_pkg::*;

  // Jobs travel from the front to the back through a short queue, so the
  // header parser never waits on the tree walk unless the queue fills up.
  logic q_push, q_full, q_valid, q_pop;
  job_t q_in, q_out;

  // The input side stalls exactly when no job slot is free.
  assign in_stall_o = q_full;

  // The front tracks where in the file the stream stands and classifies each
  // byte as a start byte, a table entry, a count byte or a bitstream byte.
  tt6u_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .item_o  (q_in)
  );

  tt6u_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // The back owns the code table, the group counter and the output register.
  // It holds the last byte of each group back until it knows whether another
  // group follows from the same input byte, which decides the run_last flag.
  tt6u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The front must never write into a full queue.
  `ASSERT_NEVER(a_no_queue_overflow, clk_i, rst_ni, q_push && q_full)
  // The final byte of a file is always the last result of its input byte.
  `ASSERT_IMP(a_done_is_last, clk_i, rst_ni, out_valid_o && out_data_o.stream_done, out_data_o.run_last)

endmodule
